// ===== rtl/bsf_pkg.sv =====
package bsf_pkg;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  // element 0 is the start point, 3 the end point
  typedef point_t [3:0] curve_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       split;
    logic       pop;
    logic       emit;
    logic       last;
    logic [1:0] sel;
  } cmd_t;

  // points taken from each leaf: q0, q1, q2
  localparam logic [1:0] SEL_FIRST = 2'd0;
  localparam logic [1:0] SEL_LAST  = 2'd2;

  // (a + b) / 2, truncating toward zero
  function automatic logic signed [15:0] half(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    logic signed [16:0] s;
    logic signed [16:0] t;
    s = {a[15], a} + {b[15], b};
    t = s + {16'b0, s[16]};
    return t[16:1];
  endfunction

endpackage

// ===== rtl/bezier_subdivision_flattener.sv =====
// Cubic curve flattener by fixed-depth binary subdivision.
// Slave channel: one request per curve. s_tdata carries p0_x, p0_y, p1_x,
// p1_y, p2_x, p2_y, p3_x, p3_y (16-bit signed each) and depth (2 bits),
// lowest bits first. Depth above MAX_DEPTH is clamped to MAX_DEPTH.
// Master channel: one polyline point per request, 3 * 2^depth per curve,
// m_tdata = point_x, point_y; m_tlast marks the final point of the curve.
// Halves are walked depth first, left before right, with the pending right
// halves kept on a small stack of MAX_DEPTH entries.
// s_tready is high only between curves. The point register lets the next
// curve be accepted while the final point still waits to be taken.
// If m_tready is low the current point is held and the walk pauses at its next point.
// Reset (rst, synchronous) returns to idle and drops m_tvalid.
module bezier_subdivision_flattener #(
  parameter int MAX_DEPTH = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, depth
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // point_x, point_y
  output logic         m_tlast
);

  localparam int LW = $clog2(MAX_DEPTH + 1);

  bsf_pkg::cmd_t   cmd;
  bsf_pkg::curve_t in_curve;
  logic [LW-1:0]   sp;
  logic            out_free;

  assign in_curve = s_tdata[127:0];

  bsf_ctrl #(
    .MAX_DEPTH(MAX_DEPTH),
    .LW       (LW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .depth   (s_tdata[129:128]),
    .out_free(out_free),
    .cmd     (cmd),
    .sp      (sp)
  );

  bsf_datapath #(
    .MAX_DEPTH(MAX_DEPTH),
    .LW       (LW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sp      (sp),
    .in_curve(in_curve),
    .out_free(out_free),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// ===== rtl/bsf_datapath.sv =====
module bsf_datapath #(
  parameter int MAX_DEPTH = 3,
  parameter int LW = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bsf_pkg::cmd_t        cmd,
  input  logic [LW-1:0]        sp,
  input  bsf_pkg::curve_t      in_curve,
  output logic                 out_free,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,
  output logic                 m_tlast
);

  localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  bsf_pkg::curve_t cur;
  bsf_pkg::curve_t stk [MAX_DEPTH];
  bsf_pkg::curve_t left_c;
  bsf_pkg::curve_t right_c;
  bsf_pkg::point_t mid;
  logic [LW-1:0]   sp_m1;

  assign sp_m1 = sp - 1'b1;

  // split: the middle point is the half of q1 and q2
  always_comb begin
    mid = '{x: bsf_pkg::half(cur[1].x, cur[2].x), y: bsf_pkg::half(cur[1].y, cur[2].y)};
    left_c[0] = cur[0];
    left_c[1] = '{x: bsf_pkg::half(cur[0].x, cur[1].x), y: bsf_pkg::half(cur[0].y, cur[1].y)};
    left_c[2] = '{x: bsf_pkg::half(mid.x, cur[1].x), y: bsf_pkg::half(mid.y, cur[1].y)};
    left_c[3] = mid;
    right_c[0] = mid;
    right_c[1] = '{x: bsf_pkg::half(mid.x, cur[2].x), y: bsf_pkg::half(mid.y, cur[2].y)};
    right_c[2] = '{x: bsf_pkg::half(cur[3].x, cur[2].x), y: bsf_pkg::half(cur[3].y, cur[2].y)};
    right_c[3] = cur[3];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= in_curve;
    end else if (cmd.split) begin
      cur <= left_c;
      stk[sp[SW-1:0]] <= right_c;
    end else if (cmd.pop) begin
      cur <= stk[sp_m1[SW-1:0]];
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= cur[cmd.sel];
      m_tlast <= cmd.last;
    end
  end

endmodule

// ===== rtl/bsf_ctrl.sv =====
module bsf_ctrl #(
  parameter int MAX_DEPTH = 3,
  parameter int LW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [1:0]    depth,
  input  logic          out_free,
  output bsf_pkg::cmd_t cmd,
  output logic [LW-1:0] sp
);

  localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [LW-1:0] lvl;
  logic [LW-1:0] lvl_next;
  logic [LW-1:0] sp_next;
  logic [1:0]    idx;
  logic [1:0]    idx_next;
  logic [LW-1:0] lvl_stk [MAX_DEPTH];
  logic [LW-1:0] sp_m1;
  logic [LW-1:0] lvl_in;
  logic [2:0]    depth_ext;

  assign s_tready  = (state == ST_IDLE);
  assign sp_m1     = sp - 1'b1;
  assign depth_ext = {1'b0, depth};
  assign lvl_in    = (depth_ext > 3'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(depth_ext);

  always_comb begin
    cmd        = '0;
    state_next = state;
    lvl_next   = lvl;
    sp_next    = sp;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          lvl_next   = lvl_in;
          sp_next    = '0;
          idx_next   = bsf_pkg::SEL_FIRST;
          state_next = (lvl_in == '0) ? ST_EMIT : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        // left half goes on, right half waits on the stack
        cmd.split  = 1'b1;
        sp_next    = sp + 1'b1;
        lvl_next   = lvl - 1'b1;
        state_next = (lvl == LW'(1)) ? ST_EMIT : ST_SPLIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = idx;
          cmd.last = (idx == bsf_pkg::SEL_LAST) && (sp == '0);
          if (idx == bsf_pkg::SEL_LAST) begin
            idx_next = bsf_pkg::SEL_FIRST;
            if (sp == '0) begin
              state_next = ST_IDLE;
            end else begin
              cmd.pop    = 1'b1;
              sp_next    = sp_m1;
              lvl_next   = lvl_stk[sp_m1[SW-1:0]];
              state_next = (lvl_stk[sp_m1[SW-1:0]] == '0) ? ST_EMIT : ST_SPLIT;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lvl   <= '0;
      sp    <= '0;
      idx   <= bsf_pkg::SEL_FIRST;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      sp    <= sp_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      lvl_stk[sp[SW-1:0]] <= lvl - 1'b1;
    end
  end

  a_no_emit_split: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.split))
    else $error("emit and split in one cycle");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= LW'(MAX_DEPTH))
    else $error("stack overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (sp != '0))
    else $error("pop from empty stack");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == ST_IDLE))
    else $error("run not closed after last point");

endmodule

// ===== verif/bezier_subdivision_flattener_test.sv =====
module bezier_subdivision_flattener_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLAMP_DEPTH  = 3;
  localparam int N_DIRECTED   = 16;
  localparam int N_RANDOM     = 460;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE       = 40;
  localparam int IDLE_PERCENT = 38;

  // one expected polyline point
  typedef struct packed {
    logic            last;
    bsf_pkg::point_t pt;
  } poly_point_t;

  // directed row: control points in order, and the leaf points written out
  // where depth is zero
  typedef struct packed {
    logic [1:0]            depth;
    bsf_pkg::point_t [0:3] q;
    logic                  typed;
    bsf_pkg::point_t [0:2] lit;
  } curve_case_t;

  localparam bsf_pkg::point_t NOPT = '0;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, depth
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;        // point_x, point_y
  logic         m_tlast;

  logic         quiet = 1'b0;   // no idling on either side while set
  int           errors = 0;
  int           cycle_count = 0;
  poly_point_t  points_due[$];
  curve_case_t  dir_tab [N_DIRECTED];

  bezier_subdivision_flattener u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[bezier_subdivision_flattener] ERROR");
      $finish;
    end
  end

  function automatic bsf_pkg::point_t mk(input int x, input int y);
    bsf_pkg::point_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    return p;
  endfunction

  // (a + b) / 2 rounded toward zero
  function automatic logic signed [15:0] avg16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    int s;
    s = int'(a) + int'(b);
    s = s / 2;
    return s[15:0];
  endfunction

  function automatic bsf_pkg::point_t avg_pt(input bsf_pkg::point_t a,
                                             input bsf_pkg::point_t b);
    bsf_pkg::point_t r;
    r.x = avg16(a.x, b.x);
    r.y = avg16(a.y, b.y);
    return r;
  endfunction

  function automatic bsf_pkg::curve_t split_half(input bsf_pkg::curve_t q, input bit right);
    bsf_pkg::curve_t h;
    bsf_pkg::point_t m;
    m = avg_pt(q[1], q[2]);
    if (!right) begin
      h[0] = q[0];
      h[1] = avg_pt(q[0], q[1]);
      h[2] = avg_pt(m, q[1]);
      h[3] = m;
    end else begin
      h[0] = m;
      h[1] = avg_pt(m, q[2]);
      h[2] = avg_pt(q[3], q[2]);
      h[3] = q[3];
    end
    return h;
  endfunction

  // leaves walked in order: path bits from the top level down, left first
  task automatic predict_polyline(input bsf_pkg::curve_t root, input logic [1:0] depth);
    int              lvl;
    int              nleaf;
    bsf_pkg::curve_t c;
    poly_point_t     e;
    lvl = (int'(depth) > CLAMP_DEPTH) ? CLAMP_DEPTH : int'(depth);
    nleaf = 1 << lvl;
    for (int leaf = 0; leaf < nleaf; leaf++) begin
      c = root;
      for (int l = lvl - 1; l >= 0; l--)
        c = split_half(c, leaf[l]);
      for (int k = 0; k < 3; k++) begin
        e.pt   = c[k];
        e.last = (leaf == nleaf - 1) && (k == 2);
        points_due.push_back(e);
      end
    end
  endtask

  // returns at the edge where the request is taken
  task automatic offer_curve(input bsf_pkg::curve_t c, input logic [1:0] depth);
    logic [135:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      v[32*i +: 16]      = c[i].x;
      v[32*i + 16 +: 16] = c[i].y;
    end
    v[129:128] = depth;
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  task automatic drain_points();
    s_tvalid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50)
      return 16'($urandom);
    else if (sel < 65)
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return -16'sd1;
        default: return 16'sd0;
      endcase
    else
      return 16'($signed($urandom_range(32)) - 16);
  endfunction

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    poly_point_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (points_due.size() == 0) begin
        $display("%0t: unexpected point expected none actual (%0d,%0d) last %b", $time,
                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
        errors++;
      end else begin
        want = points_due.pop_front();
        if (m_tdata[15:0] !== want.pt.x) begin
          $display("%0t: point_x expected %0d actual %0d", $time, want.pt.x,
                   $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[31:16] !== want.pt.y) begin
          $display("%0t: point_y expected %0d actual %0d", $time, want.pt.y,
                   $signed(m_tdata[31:16]));
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    bsf_pkg::curve_t c;
    logic [1:0]      depth;
    poly_point_t     e;

    dir_tab = '{
      '{2'd0, '{mk(-32768, -32768), mk(-32768, -32768), mk(-32768, -32768),
                mk(-32768, -32768)},
        1'b1, '{mk(-32768, -32768), mk(-32768, -32768), mk(-32768, -32768)}},
      '{2'd0, '{mk(32767, 32767), mk(32767, 32767), mk(32767, 32767), mk(32767, 32767)},
        1'b1, '{mk(32767, 32767), mk(32767, 32767), mk(32767, 32767)}},
      '{2'd0, '{mk(-32768, 32767), mk(32767, -32768), mk(-1, 1), mk(0, 0)},
        1'b1, '{mk(-32768, 32767), mk(32767, -32768), mk(-1, 1)}},
      '{2'd0, '{mk(21845, -21846), mk(-21846, 21845), mk(1, -1), mk(-2, 2)},
        1'b1, '{mk(21845, -21846), mk(-21846, 21845), mk(1, -1)}},
      '{2'd1, '{mk(32767, 32767), mk(32767, 32767), mk(32767, 32767), mk(32767, 32767)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd1, '{mk(-32768, -32768), mk(-32768, -32768), mk(-32768, -32768),
                mk(-32768, -32768)},
        1'b0, '{NOPT, NOPT, NOPT}},
      // odd negative sums: halves must round toward zero
      '{2'd1, '{mk(-1, -3), mk(0, 0), mk(-1, 1), mk(-3, -5)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd2, '{mk(-32768, 32767), mk(32767, -32768), mk(-32768, 32767),
                mk(32767, -32768)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd2, '{mk(-32768, -32768), mk(-32768, -32768), mk(-32768, -32768),
                mk(-32768, -32768)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd3, '{mk(32767, 32767), mk(32767, 32767), mk(32767, 32767), mk(32767, 32767)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd3, '{mk(-32768, -32768), mk(-32768, -32768), mk(-32768, -32768),
                mk(-32768, -32768)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd3, '{mk(-32768, -32768), mk(32767, 32767), mk(32767, -32768),
                mk(-32768, 32767)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd3, '{mk(-7, 5), mk(-3, -9), mk(11, -1), mk(-5, 3)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd1, '{mk(0, 0), mk(0, 0), mk(0, 0), mk(0, 0)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd2, '{mk(100, -200), mk(-301, 7), mk(55, -77), mk(-1, -1)},
        1'b0, '{NOPT, NOPT, NOPT}},
      '{2'd3, '{mk(0, 0), mk(-32768, 0), mk(0, 32767), mk(32767, -32768)},
        1'b0, '{NOPT, NOPT, NOPT}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      for (int k = 0; k < 4; k++)
        c[k] = dir_tab[i].q[k];
      offer_curve(c, dir_tab[i].depth);
      if (dir_tab[i].typed) begin
        for (int k = 0; k < 3; k++) begin
          e.pt   = dir_tab[i].lit[k];
          e.last = (k == 2);
          points_due.push_back(e);
        end
      end else begin
        predict_polyline(c, dir_tab[i].depth);
      end
    end
    drain_points();

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet <= (i >= 150 && i < 230);
      // hold off new requests until the polyline so far has all come out
      if (i == 300)
        drain_points();
      for (int k = 0; k < 4; k++) begin
        c[k].x = rand_coord();
        c[k].y = rand_coord();
      end
      depth = 2'($urandom_range(3));
      offer_curve(c, depth);
      predict_polyline(c, depth);
    end

    s_tvalid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0)
      $display("[bezier_subdivision_flattener] OK");
    else
      $display("[bezier_subdivision_flattener] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bsf_pkg.sv
rtl/bsf_datapath.sv
rtl/bsf_ctrl.sv
rtl/bezier_subdivision_flattener.sv
verif/bezier_subdivision_flattener_test.sv
